// ===== rtl/core/sprc_pkg.sv =====
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared types, register codes and trig tables for the sprite pixel
// rotate/flip/clip core.
// ----------------------------------------------------------------------------
package sprc_pkg;

    // Coordinate width through the rotation pipe (covers shear growth).
    localparam int CW = 14;
    // Width of the final screen-space sum.
    localparam int PW = 16;

    // Configuration register map.
    typedef enum logic [2:0] {
        REG_X_OFFSET    = 3'd0,
        REG_Y_OFFSET    = 3'd1,
        REG_FLIP_H      = 3'd2,
        REG_FLIP_V      = 3'd3,
        REG_ROTATION    = 3'd4,
        REG_WIDTH       = 3'd5,
        REG_HEIGHT      = 3'd6,
        REG_TRANSPARENT = 3'd7
    } cfg_reg_t;

    // Quarter-turn thresholds.
    localparam logic [8:0] ANG_90  = 9'd90;
    localparam logic [8:0] ANG_180 = 9'd180;
    localparam logic [8:0] ANG_270 = 9'd270;

    // Rounding bias and scale of the Q10 shear factors.
    localparam logic signed [25:0] ROUND_BIAS = 26'sd512;
    localparam int                 FRAC_BITS  = 10;

    typedef struct packed {
        logic signed [10:0] x_offset;
        logic signed [10:0] y_offset;
        logic               flip_h;
        logic               flip_v;
        logic [8:0]         rotation;
        logic [9:0]         width;
        logic [9:0]         height;
        logic [7:0]         transparent;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [10:0]          tan_k;
        logic [10:0]          sin_k;
        logic [7:0]           color;
    } coord_t;

    // round(1024*sin(a)), a = 0..89
    localparam logic [10:0] SIN_Q10 [90] = '{
        11'd0,    11'd18,   11'd36,   11'd54,   11'd71,   11'd89,   11'd107,  11'd125,
        11'd143,  11'd160,  11'd178,  11'd195,  11'd213,  11'd230,  11'd248,  11'd265,
        11'd282,  11'd299,  11'd316,  11'd333,  11'd350,  11'd367,  11'd384,  11'd400,
        11'd416,  11'd433,  11'd449,  11'd465,  11'd481,  11'd496,  11'd512,  11'd527,
        11'd543,  11'd558,  11'd573,  11'd587,  11'd602,  11'd616,  11'd630,  11'd644,
        11'd658,  11'd672,  11'd685,  11'd698,  11'd711,  11'd724,  11'd737,  11'd749,
        11'd761,  11'd773,  11'd784,  11'd796,  11'd807,  11'd818,  11'd828,  11'd839,
        11'd849,  11'd859,  11'd868,  11'd878,  11'd887,  11'd896,  11'd904,  11'd912,
        11'd920,  11'd928,  11'd935,  11'd943,  11'd949,  11'd956,  11'd962,  11'd968,
        11'd974,  11'd979,  11'd984,  11'd989,  11'd994,  11'd998,  11'd1002, 11'd1005,
        11'd1008, 11'd1011, 11'd1014, 11'd1016, 11'd1018, 11'd1020, 11'd1022, 11'd1023,
        11'd1023, 11'd1024
    };

    // round(1024*tan(h)), h = 0..44 (half angle)
    localparam logic [10:0] TAN_Q10 [45] = '{
        11'd0,   11'd18,  11'd36,  11'd54,  11'd72,  11'd90,  11'd108, 11'd126,
        11'd144, 11'd162, 11'd181, 11'd199, 11'd218, 11'd236, 11'd255, 11'd274,
        11'd294, 11'd313, 11'd333, 11'd353, 11'd373, 11'd393, 11'd414, 11'd435,
        11'd456, 11'd477, 11'd499, 11'd522, 11'd544, 11'd568, 11'd591, 11'd615,
        11'd640, 11'd665, 11'd691, 11'd717, 11'd744, 11'd772, 11'd800, 11'd829,
        11'd859, 11'd890, 11'd922, 11'd955, 11'd989
    };

    // (b*k + 512) / 1024, quotient truncated toward zero.
    function automatic logic signed [CW-1:0] shear_term(
        input logic signed [CW-1:0] b,
        input logic [10:0]          k
    );
        logic signed [25:0] prod;
        logic signed [25:0] biased;
        logic signed [25:0] quo;
        prod   = 26'(b) * 26'(signed'({1'b0, k}));
        biased = prod + ROUND_BIAS;
        quo    = biased >>> FRAC_BITS;
        if (biased < 0 && biased[FRAC_BITS-1:0] != '0)
        begin
            quo = quo + 26'sd1;
        end
        return quo[CW-1:0];
    endfunction

endpackage

// ===== rtl/core/sprc_if.sv =====
// ----------------------------------------------------------------------------
// sprc channel interfaces
// Valid/ready channels for sprite pixels in, framebuffer writes out, and
// register writes.
// ----------------------------------------------------------------------------
interface sprc_pix_if;
    logic       valid;
    logic       ready;
    logic [8:0] source_column;
    logic [8:0] source_row;
    logic [7:0] pixel_color;

    modport source (output valid, source_column, source_row, pixel_color, input ready);
    modport sink   (input valid, source_column, source_row, pixel_color, output ready);
endinterface

interface sprc_wr_if;
    logic       valid;
    logic       ready;
    logic [8:0] screen_column;
    logic [7:0] screen_row;
    logic [7:0] write_color;

    modport source (output valid, screen_column, screen_row, write_color, input ready);
    modport sink   (input valid, screen_column, screen_row, write_color, output ready);
endinterface

interface sprc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sprc_pipe_reg.sv =====
// ----------------------------------------------------------------------------
// sprc_pipe_reg
// One valid/ready pipeline register for the rotation coordinate record.
// ----------------------------------------------------------------------------
module sprc_pipe_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sprc_pkg::coord_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sprc_pkg::coord_t out_data
);

    logic             valid_reg;
    sprc_pkg::coord_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/core/sprc_prep.sv =====
// ----------------------------------------------------------------------------
// sprc_prep
// Transparency drop, mirror, centering, quarter turn and shear factor lookup.
// ----------------------------------------------------------------------------
module sprc_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  sprc_pkg::cfg_t   cfg,
    sprc_pix_if.sink         pix,
    output logic             out_valid,
    input  logic             out_ready,
    output sprc_pkg::coord_t out_data
);

    localparam int CW = sprc_pkg::CW;

    logic signed [CW-1:0] w_s, h_s, cx_s, cy_s, kw_s, kh_s;
    logic signed [CW-1:0] col_s, row_s, col_m, row_m, xc, yc, xq, yq;
    logic [8:0]           resid;
    logic                 shear_en;
    logic [6:0]           sin_idx;
    logic [5:0]           tan_idx;
    logic                 keep;
    sprc_pkg::coord_t     nxt;

    always_comb
    begin
        w_s   = signed'({{(CW-10){1'b0}}, cfg.width});
        h_s   = signed'({{(CW-10){1'b0}}, cfg.height});
        cx_s  = signed'({{(CW-9){1'b0}}, cfg.width[9:1]});
        cy_s  = signed'({{(CW-9){1'b0}}, cfg.height[9:1]});
        // w - 1 - 2*(w/2): 0 for odd sizes, -1 for even
        kw_s  = cfg.width[0]  ? '0 : '1;
        kh_s  = cfg.height[0] ? '0 : '1;
        col_s = signed'({{(CW-9){1'b0}}, pix.source_column});
        row_s = signed'({{(CW-9){1'b0}}, pix.source_row});

        col_m = cfg.flip_h ? (w_s - CW'(1) - col_s) : col_s;
        row_m = cfg.flip_v ? (h_s - CW'(1) - row_s) : row_s;
        xc    = col_m - cx_s;
        yc    = row_m - cy_s;

        priority if (cfg.rotation >= sprc_pkg::ANG_270)
        begin
            xq    = yc;
            yq    = kw_s - xc;
            resid = cfg.rotation - sprc_pkg::ANG_270;
        end
        else if (cfg.rotation >= sprc_pkg::ANG_180)
        begin
            xq    = kw_s - xc;
            yq    = kh_s - yc;
            resid = cfg.rotation - sprc_pkg::ANG_180;
        end
        else if (cfg.rotation >= sprc_pkg::ANG_90)
        begin
            xq    = kh_s - yc;
            yq    = xc;
            resid = cfg.rotation - sprc_pkg::ANG_90;
        end
        else
        begin
            xq    = xc;
            yq    = yc;
            resid = cfg.rotation;
        end

        // Zero factors make the shear stages pass the point through.
        shear_en = (resid != '0) && (resid < sprc_pkg::ANG_90);
        sin_idx  = shear_en ? resid[6:0] : '0;
        tan_idx  = shear_en ? resid[6:1] : '0;

        nxt.x     = xq;
        nxt.y     = yq;
        nxt.sin_k = shear_en ? sprc_pkg::SIN_Q10[sin_idx] : '0;
        nxt.tan_k = shear_en ? sprc_pkg::TAN_Q10[tan_idx] : '0;
        nxt.color = pix.pixel_color;

        keep = pix.valid && (pix.pixel_color != cfg.transparent);
    end

    logic             valid_reg;
    sprc_pkg::coord_t data_reg;

    assign pix.ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix.ready)
        begin
            valid_reg <= keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.ready && keep)
        begin
            data_reg <= nxt;
        end
    end

endmodule

// ===== rtl/core/sprc_place.sv =====
// ----------------------------------------------------------------------------
// sprc_place
// Un-center, add screen offsets, clip, and hold the write in the output reg.
// ----------------------------------------------------------------------------
module sprc_place #(
    parameter int SCREEN_WIDTH  = 280,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sprc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  sprc_pkg::coord_t in_data,
    sprc_wr_if.source        wr
);

    localparam int PW = sprc_pkg::PW;
    localparam logic signed [PW-1:0] SW_LIM = PW'(SCREEN_WIDTH);
    localparam logic signed [PW-1:0] SH_LIM = PW'(SCREEN_HEIGHT);

    logic signed [PW-1:0] sx, sy;
    logic                 on_screen;
    logic                 emit;

    always_comb
    begin
        sx = PW'(in_data.x) + signed'({{(PW-9){1'b0}}, cfg.width[9:1]})
             + PW'(cfg.x_offset);
        sy = PW'(in_data.y) + signed'({{(PW-9){1'b0}}, cfg.height[9:1]})
             + PW'(cfg.y_offset);
        on_screen = (sx >= 0) && (sx < SW_LIM) && (sy >= 0) && (sy < SH_LIM);
        emit      = in_valid && on_screen;
    end

    logic       valid_reg;
    logic [8:0] col_reg;
    logic [7:0] row_reg;
    logic [7:0] color_reg;

    assign in_ready         = !valid_reg || wr.ready;
    assign wr.valid         = valid_reg;
    assign wr.screen_column = col_reg;
    assign wr.screen_row    = row_reg;
    assign wr.write_color   = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && emit)
        begin
            col_reg   <= sx[8:0];
            row_reg   <= sy[7:0];
            color_reg <= in_data.color;
        end
    end

endmodule

// ===== rtl/core/sprite_pixel_rotate_flip_clip_core.sv =====
// ----------------------------------------------------------------------------
// sprite_pixel_rotate_flip_clip_core
// Places sprite pixels on screen: mirror, rotate about the sprite center,
// translate and clip, emitting one framebuffer write per visible pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pix : one transaction per sprite pixel (column, row, palette color).
//   wr  : zero or one framebuffer write per pixel, in input order. Pixels
//         with the transparent color or landing off screen produce nothing.
//   cfg : register writes (index 0..7: x/y offset, flips, rotation, sprite
//         width/height, transparent color). cfg.ready is always high; write
//         only while the pipe is empty.
// Throughput: one pixel per clock, sustained while wr is ready. The
//   critical stage is one 14x12 multiply plus round and add (one shear).
// Pipeline: five register stages (prep, three shears, output).
// Stall: each stage holds while the next one is full and not draining;
//   pix.ready drops only when all stages are full behind a stalled wr.
// Reset: pipe empties, registers load offsets 0, no flips, rotation 0,
//   size 1x1, transparent color 255.
// ----------------------------------------------------------------------------
module sprite_pixel_rotate_flip_clip_core #(
    parameter int SCREEN_WIDTH  = 280,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic      clk,
    input  logic      rst_n,
    sprc_pix_if.sink  pix,
    sprc_wr_if.source wr,
    sprc_cfg_if.sink  cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    sprc_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset    <= '0;
            cfg_reg.y_offset    <= '0;
            cfg_reg.flip_h      <= 1'b0;
            cfg_reg.flip_v      <= 1'b0;
            cfg_reg.rotation    <= '0;
            cfg_reg.width       <= 10'd1;
            cfg_reg.height      <= 10'd1;
            cfg_reg.transparent <= 8'd255;
        end
        else if (cfg.valid)
        begin
            unique case (sprc_pkg::cfg_reg_t'(cfg.index))
                sprc_pkg::REG_X_OFFSET:    cfg_reg.x_offset    <= signed'(cfg.data);
                sprc_pkg::REG_Y_OFFSET:    cfg_reg.y_offset    <= signed'(cfg.data);
                sprc_pkg::REG_FLIP_H:      cfg_reg.flip_h      <= cfg.data[0];
                sprc_pkg::REG_FLIP_V:      cfg_reg.flip_v      <= cfg.data[0];
                sprc_pkg::REG_ROTATION:    cfg_reg.rotation    <= cfg.data[8:0];
                sprc_pkg::REG_WIDTH:       cfg_reg.width       <= cfg.data[9:0];
                sprc_pkg::REG_HEIGHT:      cfg_reg.height      <= cfg.data[9:0];
                sprc_pkg::REG_TRANSPARENT: cfg_reg.transparent <= cfg.data[7:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: drop transparent, mirror, center, quarter turn, table lookup
    // ------------------------------------------------------------------
    logic             p_valid, p_ready;
    sprc_pkg::coord_t p_data;

    sprc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix       (pix),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    // ------------------------------------------------------------------
    // Stages 2-4: the three shears, one multiply each
    //   x -= rnd(y*T), y += rnd(x*S), x -= rnd(y*T)
    // ------------------------------------------------------------------
    logic             s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
    sprc_pkg::coord_t s1_in, s1_data, s2_in, s2_data, s3_in, s3_data;

    always_comb
    begin
        s1_in   = p_data;
        s1_in.x = p_data.x - sprc_pkg::shear_term(p_data.y, p_data.tan_k);
        s2_in   = s1_data;
        s2_in.y = s1_data.y + sprc_pkg::shear_term(s1_data.x, s1_data.sin_k);
        s3_in   = s2_data;
        s3_in.x = s2_data.x - sprc_pkg::shear_term(s2_data.y, s2_data.tan_k);
    end

    sprc_pipe_reg u_shear1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (s1_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    sprc_pipe_reg u_shear2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s2_in),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sprc_pipe_reg u_shear3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s3_in),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // ------------------------------------------------------------------
    // Stage 5: back to sprite origin, offsets, clip, output register
    // ------------------------------------------------------------------
    sprc_place #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_place (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s3_valid),
        .in_ready (s3_ready),
        .in_data  (s3_data),
        .wr       (wr)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sprite pixel rotate/flip/clip core. A directed
// table covers reset values, screen edges, transparency, each quarter turn,
// shear angles, angles past 359, zero sprite size and extreme offsets. Then
// random phases reprogram all registers and stream pixels under bursty input
// and a stalling output. Every framebuffer write is checked against the
// oldest owed write, from a hand-written expectation or the placement model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCREEN_W        = 280;
    localparam int SCREEN_H        = 240;
    localparam int Q10_ONE         = 1024;
    localparam int Q10_HALF        = 512;
    localparam int SETTLE_CYCLES   = 8;      // flush time for dropped pixels in the pipe
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_HOLD       = 300;    // output stall that backs up the pipe
    localparam int RANDOM_PHASES   = 17;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 500000;

    // round(1024*sin(a)), a = 0..89
    localparam int SINE_K [90] = '{
        0, 18, 36, 54, 71, 89, 107, 125, 143, 160,
        178, 195, 213, 230, 248, 265, 282, 299, 316, 333,
        350, 367, 384, 400, 416, 433, 449, 465, 481, 496,
        512, 527, 543, 558, 573, 587, 602, 616, 630, 644,
        658, 672, 685, 698, 711, 724, 737, 749, 761, 773,
        784, 796, 807, 818, 828, 839, 849, 859, 868, 878,
        887, 896, 904, 912, 920, 928, 935, 943, 949, 956,
        962, 968, 974, 979, 984, 989, 994, 998, 1002, 1005,
        1008, 1011, 1014, 1016, 1018, 1020, 1022, 1023, 1023, 1024
    };

    // round(1024*tan(h)), h = 0..44 (half angle)
    localparam int HALF_TAN_K [45] = '{
        0, 18, 36, 54, 72, 90, 108, 126, 144, 162,
        181, 199, 218, 236, 255, 274, 294, 313, 333, 353,
        373, 393, 414, 435, 456, 477, 499, 522, 544, 568,
        591, 615, 640, 665, 691, 717, 744, 772, 800, 829,
        859, 890, 922, 955, 989
    };

    typedef struct packed {
        logic [8:0] column;
        logic [7:0] row;
        logic [7:0] color;
    } screen_write_t;

    // Bench copy of the register file.
    typedef struct packed {
        logic signed [10:0] x_offset;
        logic signed [10:0] y_offset;
        logic               flip_h;
        logic               flip_v;
        logic [8:0]         rotation;
        logic [9:0]         width;
        logic [9:0]         height;
        logic [7:0]         transparent;
    } placer_regs_t;

    // One row of the directed table: a register write or a pixel. A pixel row
    // may carry a hand-written expectation (known), else the model decides.
    typedef struct {
        bit                  is_cfg;
        sprc_pkg::cfg_reg_t  idx;
        logic [10:0]         data;
        logic [8:0]          column;
        logic [8:0]          row;
        logic [7:0]          color;
        bit                  known;
        bit                  hit;
        screen_write_t       result;
    } directed_row_t;

    logic clk;
    logic rst_n;

    sprc_pix_if pix_bus ();
    sprc_wr_if  wr_bus ();
    sprc_cfg_if cfg_bus ();

    sprite_pixel_rotate_flip_clip_core #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .wr    (wr_bus),
        .cfg   (cfg_bus)
    );

    placer_regs_t  shadow_regs;
    screen_write_t pending_writes [$];
    directed_row_t directed_rows [$];
    int            err_count;
    int            cycle_count;
    int            rx_mode;    // output stall pattern for the current phase
    int            hold_req;   // bumped to ask the sink for one long hold-off

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Placement model: transparency drop, mirror, center, quarter turn, three
    // shears, uncenter, offset, clip. Returns 1 when a write is produced.
    // ------------------------------------------------------------------------
    function automatic bit place_pixel(input logic [8:0] src_col, input logic [8:0] src_row,
                                       input logic [7:0] color, output screen_write_t wr_out);
        int col, row, w, h, cx, cy, ang, x, y, t, tq, sq, sx, sy;
        wr_out = '0;
        col = int'(src_col);
        row = int'(src_row);
        w   = int'(shadow_regs.width);
        h   = int'(shadow_regs.height);
        cx  = w / 2;
        cy  = h / 2;
        ang = int'(shadow_regs.rotation);
        if (color == shadow_regs.transparent)
        begin
            return 1'b0;
        end
        if (shadow_regs.flip_h)
        begin
            col = w - 1 - col;
        end
        if (shadow_regs.flip_v)
        begin
            row = h - 1 - row;
        end
        x = col - cx;
        y = row - cy;
        // Quarter turns. Angles past 359 fall into the 270 branch and leave a
        // remainder of 90 or more, so no shears follow.
        if (ang >= 270)
        begin
            t   = x;
            x   = y;
            y   = w - 1 - 2 * cx - t;
            ang = ang - 270;
        end
        else if (ang >= 180)
        begin
            x   = w - 1 - 2 * cx - x;
            y   = h - 1 - 2 * cy - y;
            ang = ang - 180;
        end
        else if (ang >= 90)
        begin
            t   = x;
            x   = h - 1 - 2 * cy - y;
            y   = t;
            ang = ang - 90;
        end
        // Fine rotation; SV integer divide truncates toward zero.
        if (ang > 0 && ang < 90)
        begin
            tq = HALF_TAN_K[ang / 2];
            sq = SINE_K[ang];
            x  = x - (y * tq + Q10_HALF) / Q10_ONE;
            y  = (x * sq + Q10_HALF) / Q10_ONE + y;
            x  = x - (y * tq + Q10_HALF) / Q10_ONE;
        end
        sx = x + cx + int'($signed(shadow_regs.x_offset));
        sy = y + cy + int'($signed(shadow_regs.y_offset));
        if (sx < 0 || sx >= SCREEN_W || sy < 0 || sy >= SCREEN_H)
        begin
            return 1'b0;
        end
        wr_out.column = sx[8:0];
        wr_out.row    = sy[7:0];
        wr_out.color  = color;
        return 1'b1;
    endfunction

    function automatic logic [9:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return 10'($urandom_range(1, 64));
        end
        else if (r < 9)
        begin
            return 10'($urandom_range(65, 511));
        end
        return 10'd512;
    endfunction

    function automatic void add_cfg(input sprc_pkg::cfg_reg_t idx, input logic [10:0] value);
        directed_row_t d;
        d = '{idx: sprc_pkg::REG_X_OFFSET, default: '0};
        d.is_cfg = 1'b1;
        d.idx    = idx;
        d.data   = value;
        directed_rows.push_back(d);
    endfunction

    function automatic void add_pix(input logic [8:0] c, input logic [8:0] r,
                                    input logic [7:0] k);
        directed_row_t d;
        d = '{idx: sprc_pkg::REG_X_OFFSET, default: '0};
        d.idx    = sprc_pkg::REG_X_OFFSET;
        d.column = c;
        d.row    = r;
        d.color  = k;
        directed_rows.push_back(d);
    endfunction

    // Pixel with a hand-written outcome: hit = 1 means a write at (tc, tr).
    function automatic void add_known(input logic [8:0] c, input logic [8:0] r,
                                      input logic [7:0] k, input bit hit,
                                      input logic [8:0] tc, input logic [7:0] tr);
        directed_row_t d;
        d = '{idx: sprc_pkg::REG_X_OFFSET, default: '0};
        d.idx    = sprc_pkg::REG_X_OFFSET;
        d.column = c;
        d.row    = r;
        d.color  = k;
        d.known  = 1'b1;
        d.hit    = hit;
        d.result = '{column: tc, row: tr, color: k};
        directed_rows.push_back(d);
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Both are entered at a falling edge and return at the
    // falling edge after the transaction with valid still high, so a
    // back-to-back transaction never lowers and raises valid in one step.
    // ------------------------------------------------------------------------
    task automatic write_reg(input sprc_pkg::cfg_reg_t idx, input logic [10:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            sprc_pkg::REG_X_OFFSET:    shadow_regs.x_offset    = value;
            sprc_pkg::REG_Y_OFFSET:    shadow_regs.y_offset    = value;
            sprc_pkg::REG_FLIP_H:      shadow_regs.flip_h      = value[0];
            sprc_pkg::REG_FLIP_V:      shadow_regs.flip_v      = value[0];
            sprc_pkg::REG_ROTATION:    shadow_regs.rotation    = value[8:0];
            sprc_pkg::REG_WIDTH:       shadow_regs.width       = value[9:0];
            sprc_pkg::REG_HEIGHT:      shadow_regs.height      = value[9:0];
            sprc_pkg::REG_TRANSPARENT: shadow_regs.transparent = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic push_pixel(input logic [8:0] c, input logic [8:0] r, input logic [7:0] k,
                              input bit known, input bit known_hit,
                              input screen_write_t known_wr);
        screen_write_t pred;
        pix_bus.valid         <= 1'b1;
        pix_bus.source_column <= c;
        pix_bus.source_row    <= r;
        pix_bus.pixel_color   <= k;
        do @(posedge clk); while (pix_bus.ready !== 1'b1);
        // Transaction accepted: record what the output side owes us.
        if (known)
        begin
            if (known_hit)
            begin
                pending_writes.push_back(known_wr);
            end
        end
        else if (place_pixel(c, r, k, pred))
        begin
            pending_writes.push_back(pred);
        end
        @(negedge clk);
    endtask

    // Wait for all owed writes, then let dropped pixels still in the pipe
    // flush before any register is touched.
    task automatic settle_pipe();
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output sink: per-phase stall pattern, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin : write_sink
        int hold_seen;
        int hold_left;
        bit rdy;
        hold_seen    = 0;
        hold_left    = 0;
        rdy          = 1'b1;
        wr_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rdy       = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 1);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        // long runs of ready and of stall
                        if ($urandom_range(0, 7) == 0)
                        begin
                            rdy = !rdy;
                        end
                    end
                endcase
            end
            wr_bus.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: every write must match the oldest owed write.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : write_check
        screen_write_t want;
        if (rst_n === 1'b1 && wr_bus.valid === 1'b1 && wr_bus.ready === 1'b1)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: column %0d row %0d color %0d",
                       wr_bus.screen_column, wr_bus.screen_row, wr_bus.write_color);
                err_count = err_count + 1;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (wr_bus.screen_column !== want.column)
                begin
                    $error("screen_column: expected %0d, actual %0d",
                           want.column, wr_bus.screen_column);
                    err_count = err_count + 1;
                end
                if (wr_bus.screen_row !== want.row)
                begin
                    $error("screen_row: expected %0d, actual %0d",
                           want.row, wr_bus.screen_row);
                    err_count = err_count + 1;
                end
                if (wr_bus.write_color !== want.color)
                begin
                    $error("write_color: expected %0d, actual %0d",
                           want.color, wr_bus.write_color);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // Watchdog on cycle count.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit                 cfg_busy;
        int                 sent;
        int                 burst;
        int                 gap;
        int                 gap_max;
        logic [9:0]         w_sel;
        logic [9:0]         h_sel;
        logic [8:0]         rot_sel;
        logic signed [10:0] xo_sel;
        logic signed [10:0] yo_sel;
        logic               fh_sel;
        logic               fv_sel;
        logic [7:0]         tr_sel;
        logic [8:0]         c;
        logic [8:0]         r;
        logic [7:0]         k;

        // Drive every input to a known value from time zero.
        rst_n                 = 1'b0;
        pix_bus.valid         = 1'b0;
        pix_bus.source_column = '0;
        pix_bus.source_row    = '0;
        pix_bus.pixel_color   = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = sprc_pkg::REG_X_OFFSET;
        cfg_bus.data          = '0;
        rx_mode               = 0;
        hold_req              = 0;
        err_count             = 0;
        cfg_busy              = 1'b0;

        // Register values after reset.
        shadow_regs.x_offset    = '0;
        shadow_regs.y_offset    = '0;
        shadow_regs.flip_h      = 1'b0;
        shadow_regs.flip_v      = 1'b0;
        shadow_regs.rotation    = '0;
        shadow_regs.width       = 10'd1;
        shadow_regs.height      = 10'd1;
        shadow_regs.transparent = 8'd255;

        // Directed table. Reset config is a 1x1 sprite at the origin, so the
        // source position lands on screen unchanged.
        add_known(9'd0,   9'd0,   8'h00, 1'b1, 9'd0,   8'd0);
        add_known(9'd0,   9'd0,   8'hFF, 1'b0, 9'd0,   8'd0);   // transparent
        add_known(9'd279, 9'd239, 8'hAA, 1'b1, 9'd279, 8'd239); // last on-screen spot
        add_known(9'd280, 9'd0,   8'h55, 1'b0, 9'd0,   8'd0);   // one column past edge
        add_known(9'd0,   9'd240, 8'h55, 1'b0, 9'd0,   8'd0);   // one row past edge
        add_known(9'd511, 9'd511, 8'h01, 1'b0, 9'd0,   8'd0);
        add_cfg(sprc_pkg::REG_TRANSPARENT, 11'd0);
        add_known(9'd5,   9'd5,   8'h00, 1'b0, 9'd0,   8'd0);
        add_known(9'd5,   9'd5,   8'hFF, 1'b1, 9'd5,   8'd5);
        // Largest sprite, centered on screen; each quarter turn and shears.
        add_cfg(sprc_pkg::REG_WIDTH, 11'd512);
        add_cfg(sprc_pkg::REG_HEIGHT, 11'd512);
        add_cfg(sprc_pkg::REG_X_OFFSET, 11'(-116));
        add_cfg(sprc_pkg::REG_Y_OFFSET, 11'(-136));
        add_cfg(sprc_pkg::REG_ROTATION, 11'd90);
        add_pix(9'd300, 9'd100, 8'h11);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd180);
        add_pix(9'd300, 9'd100, 8'h12);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd270);
        add_pix(9'd300, 9'd100, 8'h13);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd45);
        add_pix(9'd511, 9'd0, 8'h14);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd1);
        add_pix(9'd0, 9'd511, 8'h15);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd89);
        add_pix(9'd256, 9'd256, 8'h16);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd359);
        add_pix(9'd400, 9'd50, 8'h17);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd511);             // past 359
        add_pix(9'd100, 9'd400, 8'h18);
        add_cfg(sprc_pkg::REG_FLIP_H, 11'd1);
        add_cfg(sprc_pkg::REG_FLIP_V, 11'd1);
        add_cfg(sprc_pkg::REG_ROTATION, 11'd30);
        add_pix(9'd0, 9'd0, 8'h19);
        add_pix(9'd511, 9'd511, 8'h1A);
        // Zero-size sprite: mirror goes negative.
        add_cfg(sprc_pkg::REG_WIDTH, 11'd0);
        add_cfg(sprc_pkg::REG_HEIGHT, 11'd0);
        add_cfg(sprc_pkg::REG_X_OFFSET, 11'd0);
        add_cfg(sprc_pkg::REG_Y_OFFSET, 11'd0);
        add_pix(9'd0, 9'd0, 8'h1B);
        add_pix(9'd100, 9'd50, 8'h1C);
        // Offset extremes.
        add_cfg(sprc_pkg::REG_X_OFFSET, 11'd1023);
        add_pix(9'd0, 9'd0, 8'h1D);
        add_cfg(sprc_pkg::REG_X_OFFSET, 11'h400);             // -1024
        add_cfg(sprc_pkg::REG_Y_OFFSET, 11'd1023);
        add_pix(9'd511, 9'd511, 8'h1E);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table. Register writes wait for an empty pipe.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                if (!cfg_busy)
                begin
                    pix_bus.valid <= 1'b0;
                    settle_pipe();
                end
                write_reg(directed_rows[i].idx, directed_rows[i].data);
                cfg_busy = 1'b1;
            end
            else
            begin
                if (cfg_busy)
                begin
                    cfg_bus.valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                push_pixel(directed_rows[i].column, directed_rows[i].row,
                           directed_rows[i].color, directed_rows[i].known,
                           directed_rows[i].hit, directed_rows[i].result);
            end
        end
        pix_bus.valid <= 1'b0;

        // Random phases: reprogram every register, then stream pixels.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_pipe();
            if (p == 0)
            begin
                // largest sprite, nearly full turn, both flips
                w_sel   = 10'd512;
                h_sel   = 10'd512;
                rot_sel = 9'd359;
                xo_sel  = -11'sd116;
                yo_sel  = -11'sd136;
                fh_sel  = 1'b1;
                fv_sel  = 1'b1;
                tr_sel  = 8'd255;
            end
            else if (p == 1)
            begin
                // smallest sprite, identity placement
                w_sel   = 10'd1;
                h_sel   = 10'd1;
                rot_sel = 9'd0;
                xo_sel  = '0;
                yo_sel  = '0;
                fh_sel  = 1'b0;
                fv_sel  = 1'b0;
                tr_sel  = 8'd0;
            end
            else
            begin
                w_sel = pick_size();
                h_sel = pick_size();
                case ($urandom_range(0, 9))
                    0:
                    begin
                        case ($urandom_range(0, 7))
                            0:       rot_sel = 9'd0;
                            1:       rot_sel = 9'd90;
                            2:       rot_sel = 9'd180;
                            3:       rot_sel = 9'd270;
                            4:       rot_sel = 9'd1;
                            5:       rot_sel = 9'd89;
                            6:       rot_sel = 9'd359;
                            default: rot_sel = 9'($urandom_range(360, 511));
                        endcase
                    end
                    default: rot_sel = 9'($urandom_range(0, 359));
                endcase
                // Mostly keep the sprite center on screen so writes are common.
                if ($urandom_range(0, 4) != 0)
                begin
                    xo_sel = 11'(int'($urandom_range(0, SCREEN_W - 1)) - int'(w_sel) / 2);
                    yo_sel = 11'(int'($urandom_range(0, SCREEN_H - 1)) - int'(h_sel) / 2);
                end
                else
                begin
                    xo_sel = 11'($urandom_range(0, 2047));
                    yo_sel = 11'($urandom_range(0, 2047));
                end
                fh_sel = 1'($urandom_range(0, 1));
                fv_sel = 1'($urandom_range(0, 1));
                tr_sel = 8'($urandom_range(0, 255));
            end
            write_reg(sprc_pkg::REG_X_OFFSET, xo_sel);
            write_reg(sprc_pkg::REG_Y_OFFSET, yo_sel);
            write_reg(sprc_pkg::REG_FLIP_H, {10'd0, fh_sel});
            write_reg(sprc_pkg::REG_FLIP_V, {10'd0, fv_sel});
            write_reg(sprc_pkg::REG_ROTATION, {2'd0, rot_sel});
            write_reg(sprc_pkg::REG_WIDTH, {1'b0, w_sel});
            write_reg(sprc_pkg::REG_HEIGHT, {1'b0, h_sel});
            write_reg(sprc_pkg::REG_TRANSPARENT, {3'd0, tr_sel});
            cfg_bus.valid <= 1'b0;

            rx_mode = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 4;
                default: gap_max = 12;
            endcase
            // Long output hold-off while input keeps coming: pipe fills and
            // pix.ready must drop.
            if (p % 7 == 4)
            begin
                hold_req = hold_req + 1;
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && sent < ITEMS_PER_PHASE)
                begin
                    // Mostly pixels inside the sprite; some from anywhere.
                    if ($urandom_range(0, 99) < 85)
                    begin
                        c = 9'($urandom_range(0, int'(shadow_regs.width) - 1));
                        r = 9'($urandom_range(0, int'(shadow_regs.height) - 1));
                    end
                    else
                    begin
                        c = 9'($urandom_range(0, 511));
                        r = 9'($urandom_range(0, 511));
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        k = shadow_regs.transparent;
                    end
                    else
                    begin
                        k = 8'($urandom_range(0, 255));
                    end
                    push_pixel(c, r, k, 1'b0, 1'b0, '0);
                    sent  = sent + 1;
                    burst = burst - 1;
                    // Sender pause mid-stream until the output side catches up.
                    if (p == 7 && sent == ITEMS_PER_PHASE / 2)
                    begin
                        pix_bus.valid <= 1'b0;
                        settle_pipe();
                    end
                end
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    pix_bus.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            pix_bus.valid <= 1'b0;
        end

        // Drain and report.
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
